// ===== sv/tev_pkg.sv =====
// Shared types and constants of the timed event queue.
package tev_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned TIME_BITS_DEF   = 48;
  localparam int unsigned TIME_PORT_W     = 48;
  localparam int unsigned MAX_RESULTS     = 16;
  localparam int unsigned LIMIT_W         = 5;
  localparam int unsigned NFIRE_W         = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_REMOVE  = 2'd1,
    CMD_EXECUTE = 2'd2,
    CMD_SERVICE = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_QUEUED    = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_FULL      = 3'd2,
    ST_NONE_DUE  = 3'd3,
    ST_FIRED     = 3'd4
  } status_e;

  // Stored payload of one event, time kept apart.
  typedef struct packed {
    logic [31:0] ident;
    logic [2:0]  kind;
    logic [15:0] target;
    logic [15:0] size;
    logic [31:0] value;
  } payload_t;

  // Update of the order row.
  typedef struct packed {
    logic ins;
    logic del;
  } ord_op_t;

endpackage

// ===== sv/tev_mem.sv =====
// Slot memory of the timed event queue: due times and payloads.
module tev_mem #(
  parameter int unsigned DEPTH = tev_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned TW    = tev_pkg::TIME_BITS_DEF,
  localparam int unsigned IW   = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [IW-1:0]     waddr_i,
  input  logic [TW-1:0]     wtime_i,
  input  tev_pkg::payload_t wpay_i,
  input  logic              re_i,
  input  logic [IW-1:0]     raddr_i,
  output logic [TW-1:0]     rtime_o,
  output tev_pkg::payload_t rpay_o
);
  import tev_pkg::*;

  logic [TW-1:0] mem_time [DEPTH];
  payload_t      mem_pay  [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_time[waddr_i] <= wtime_i;
      mem_pay[waddr_i]  <= wpay_i;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rtime_o <= mem_time[raddr_i];
      rpay_o  <= mem_pay[raddr_i];
    end
  end

endmodule

// ===== sv/tev_order.sv =====
// Order row: queue position to memory slot, free slots at the tail.
module tev_order #(
  parameter int unsigned DEPTH = tev_pkg::QUEUE_DEPTH_DEF,
  localparam int unsigned IW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tev_pkg::ord_op_t op_i,
  input  logic [IW-1:0]    pos_i,
  input  logic [IW-1:0]    gone_i,
  input  logic [IW-1:0]    idx_i,
  output logic [IW-1:0]    slot_o,
  output logic [IW-1:0]    free_o
);
  import tev_pkg::*;

  logic [IW-1:0] ord_q [DEPTH];
  logic [IW-1:0] ord_d [DEPTH];

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ord_d[i] = ord_q[i];
      if (op_i.ins && (IW'(i) > pos_i) && (i > 0)) begin
        ord_d[i] = ord_q[(i > 0) ? i - 1 : 0];
      end else if (op_i.ins && (IW'(i) == pos_i)) begin
        ord_d[i] = ord_q[DEPTH-1];
      end else if (op_i.del && (i == DEPTH - 1)) begin
        ord_d[i] = gone_i;
      end else if (op_i.del && (IW'(i) >= pos_i) && (i < DEPTH - 1)) begin
        ord_d[i] = ord_q[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) ord_q[i] <= IW'(i);
    end else begin
      for (int i = 0; i < DEPTH; i++) ord_q[i] <= ord_d[i];
    end
  end

  assign slot_o = ord_q[idx_i];
  assign free_o = ord_q[DEPTH-1];

endmodule

// ===== sv/timed_event_queue.sv =====
// Top level of the timed event queue: command sequencer and result register.
//
//  channel | direction | handshake               | beat
//  in      | in        | in_valid_i / in_stall_o | one command
//  out     | out       | out_valid_o/out_stall_i | one result
//  cfg     | in        | cfg_we_i                | max_events_limit
//
// A command walks the queue in order; each entry looked at takes a read step
// and a test step (read the slot memory, test the data), and the registered
// read of the slot memory sets that pace.
// Service fires one entry per visit; each result waits for the output slot.
// Reset empties the queue at once (order row reset, count zero); no clearing.
// Input is stalled from acceptance until the final result is in the output
// register; the output register holds while out_stall_i is high.
module timed_event_queue #(
  parameter int unsigned QUEUE_DEPTH = tev_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned TIME_BITS   = tev_pkg::TIME_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [47:0] time_value_i,
  input  logic [31:0] event_id_i,
  input  logic [2:0]  action_kind_i,
  input  logic [15:0] target_handle_i,
  input  logic [15:0] bitmap_size_i,
  input  logic signed [31:0] action_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] result_id_o,
  output logic [2:0]  fired_kind_o,
  output logic [15:0] fired_target_o,
  output logic [15:0] fired_size_o,
  output logic signed [31:0] fired_value_o,
  output logic [47:0] fire_time_o,
  output logic        last_result_o
);
  import tev_pkg::*;

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TW = TIME_BITS;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_TEST = 4'b0100,
    S_END  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Command registers.
  cmd_e          cmd_q;
  logic [TW-1:0] t_q;
  payload_t      pay_q;
  logic [CW-1:0] idx_q, idx_d;
  logic [IW-1:0] slot_q, slot_d;
  logic          found_q, found_d, full_q, full_d;
  logic [NFIRE_W-1:0] nfire_q, nfire_d;

  // Held fired event, sent once the next one is known.
  logic     hold_vld_q, hold_vld_d;
  payload_t hold_q, hold_d;

  // Queue state.
  logic [CW-1:0]      count_q, count_d;
  logic [31:0]        next_id_q, next_id_d;
  logic [LIMIT_W-1:0] limit_q;

  // Output register.
  logic        out_vld_q, out_vld_d;
  logic [2:0]  o_status_q, o_status_d;
  payload_t    o_pay_q, o_pay_d;
  logic [47:0] o_time_q, o_time_d;
  logic        o_last_q, o_last_d;
  logic        out_free, load;

  logic [TW-1:0] t_in, rtime;
  logic [47:0]   t_out;
  payload_t      rpay, wpay;
  logic [IW-1:0] ord_slot, ord_free;
  ord_op_t       ord_op;
  logic          mem_re, mem_we, accept, full_now;
  int unsigned   lim_eff;

  // Widen or cut the time field to TIME_BITS and back.
  always_comb begin
    for (int b = 0; b < TW; b++) t_in[b] = (b < 48) ? time_value_i[b] : 1'b0;
    for (int b = 0; b < 48; b++) t_out[b] = (b < TW) ? t_q[b] : 1'b0;
  end

  assign lim_eff  = (limit_q == '0 || int'(limit_q) > QUEUE_DEPTH) ?
                    QUEUE_DEPTH : int'(limit_q);
  assign full_now = int'(count_q) >= lim_eff;
  assign accept   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free = !out_vld_q || !out_stall_i;

  // A new event is stored under the identifier it is given, not the search id.
  assign wpay = '{ident: next_id_q, kind: pay_q.kind, target: pay_q.target,
                  size: pay_q.size, value: pay_q.value};

  tev_order #(.DEPTH(QUEUE_DEPTH)) u_order (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (ord_op),
    .pos_i  (idx_q[IW-1:0]),
    .gone_i (slot_q),
    .idx_i  (idx_q[IW-1:0]),
    .slot_o (ord_slot),
    .free_o (ord_free)
  );

  tev_mem #(.DEPTH(QUEUE_DEPTH), .TW(TW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (ord_free),
    .wtime_i (t_q),
    .wpay_i  (wpay),
    .re_i    (mem_re),
    .raddr_i (ord_slot),
    .rtime_o (rtime),
    .rpay_o  (rpay)
  );

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    slot_d     = slot_q;
    found_d    = found_q;
    full_d     = full_q;
    nfire_d    = nfire_q;
    hold_vld_d = hold_vld_q;
    hold_d     = hold_q;
    count_d    = count_q;
    next_id_d  = next_id_q;
    ord_op     = '0;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    load       = 1'b0;
    o_status_d = ST_QUEUED;
    o_pay_d    = '0;
    o_time_d   = '0;
    o_last_d   = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          idx_d      = '0;
          found_d    = 1'b0;
          nfire_d    = '0;
          hold_vld_d = 1'b0;
          full_d     = (cmd_e'(command_i) == CMD_INSERT) && full_now;
          state_d    = full_d ? S_END : S_READ;
        end
      end
      S_READ: begin
        // Stop at the end of the queue or when service hit its result cap.
        if (idx_q == count_q ||
            (cmd_q == CMD_SERVICE && int'(nfire_q) == MAX_RESULTS)) begin
          state_d = S_END;
        end else begin
          mem_re  = 1'b1;
          slot_d  = ord_slot;
          state_d = S_TEST;
        end
      end
      S_TEST: begin
        unique case (cmd_q)
          CMD_INSERT: begin
            if (rtime >= t_q) state_d = S_END;
            else begin
              idx_d   = idx_q + CW'(1);
              state_d = S_READ;
            end
          end
          CMD_REMOVE, CMD_EXECUTE: begin
            if (rpay.ident == pay_q.ident) begin
              found_d = 1'b1;
              state_d = S_END;
            end else begin
              idx_d   = idx_q + CW'(1);
              state_d = S_READ;
            end
          end
          default: begin
            if (rtime > t_q) state_d = S_END;
            else if (!hold_vld_q || out_free) begin
              // Send the held event, hold this one, drop it from the head.
              if (hold_vld_q) begin
                load       = 1'b1;
                o_status_d = ST_FIRED;
                o_pay_d    = hold_q;
                o_time_d   = t_out;
                o_last_d   = 1'b0;
              end
              hold_vld_d = 1'b1;
              hold_d     = rpay;
              nfire_d    = nfire_q + NFIRE_W'(1);
              ord_op.del = 1'b1;
              count_d    = count_q - CW'(1);
              state_d    = S_READ;
            end
          end
        endcase
      end
      S_END: begin
        if (out_free) begin
          load    = 1'b1;
          state_d = S_IDLE;
          unique case (cmd_q)
            CMD_INSERT: begin
              if (full_q) o_status_d = ST_FULL;
              else begin
                mem_we        = 1'b1;
                ord_op.ins    = 1'b1;
                count_d       = count_q + CW'(1);
                next_id_d     = next_id_q + 32'd1;
                o_status_d    = ST_QUEUED;
                o_pay_d.ident = next_id_q;
              end
            end
            CMD_REMOVE, CMD_EXECUTE: begin
              if (!found_q) o_status_d = ST_NOT_FOUND;
              else begin
                ord_op.del = 1'b1;
                count_d    = count_q - CW'(1);
                if (cmd_q == CMD_EXECUTE) begin
                  o_status_d = ST_FIRED;
                  o_pay_d    = rpay;
                end else begin
                  o_status_d    = ST_QUEUED;
                  o_pay_d.ident = rpay.ident;
                end
              end
            end
            default: begin
              if (hold_vld_q) begin
                o_status_d = ST_FIRED;
                o_pay_d    = hold_q;
                o_time_d   = t_out;
              end else begin
                o_status_d = ST_NONE_DUE;
              end
              hold_vld_d = 1'b0;
            end
          endcase
        end
      end
      default: state_d = S_IDLE;
    endcase

    out_vld_d = load || (out_vld_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      idx_q      <= '0;
      found_q    <= 1'b0;
      full_q     <= 1'b0;
      nfire_q    <= '0;
      hold_vld_q <= 1'b0;
      count_q    <= '0;
      next_id_q  <= 32'd1;
      limit_q    <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      found_q    <= found_d;
      full_q     <= full_d;
      nfire_q    <= nfire_d;
      hold_vld_q <= hold_vld_d;
      count_q    <= count_d;
      next_id_q  <= next_id_d;
      out_vld_q  <= out_vld_d;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
    end
  end

  // Payload registers: capture the command, hold results while stalled.
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    hold_q <= hold_d;
    if (accept) begin
      cmd_q         <= cmd_e'(command_i);
      t_q           <= t_in;
      pay_q.ident   <= event_id_i;
      pay_q.kind    <= action_kind_i;
      pay_q.target  <= target_handle_i;
      pay_q.size    <= bitmap_size_i;
      pay_q.value   <= action_value_i;
    end
    if (load) begin
      o_status_q <= o_status_d;
      o_pay_q    <= o_pay_d;
      o_time_q   <= o_time_d;
      o_last_q   <= o_last_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign status_o       = o_status_q;
  assign result_id_o    = o_pay_q.ident;
  assign fired_kind_o   = o_pay_q.kind;
  assign fired_target_o = o_pay_q.target;
  assign fired_size_o   = o_pay_q.size;
  assign fired_value_o  = o_pay_q.value;
  assign fire_time_o    = o_time_q;
  assign last_result_o  = o_last_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) <= QUEUE_DEPTH)
    else $error("pending count beyond depth");

  a_idle_no_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !hold_vld_q)
    else $error("held event left behind at idle");

  a_end_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_END && out_free) |=> (state_q == S_IDLE && out_vld_q && o_last_q))
    else $error("command closed without a final result");

  a_id_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (next_id_q != $past(next_id_q)) |-> (out_vld_q && o_status_q == ST_QUEUED))
    else $error("identifier advanced without a queued insert");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench of the timed event queue.
module tb_top;
  import tev_pkg::*;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned WDOG_MAX  = 20000;

  // One result beat as the block presents it.
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] id;
    logic [2:0]  kind;
    logic [15:0] target;
    logic [15:0] size;
    logic [31:0] value;
    logic [47:0] ftime;
    logic        last;
  } result_t;

  // Predicts the queue and holds the results still owed by the block.
  class event_scoreboard;
    logic [47:0] q_time[DEPTH];
    logic [31:0] q_id[DEPTH];
    logic [2:0]  q_kind[DEPTH];
    logic [15:0] q_target[DEPTH];
    logic [15:0] q_size[DEPTH];
    logic [31:0] q_value[DEPTH];
    int unsigned count;
    logic [31:0] next_id;
    logic [4:0]  limit_reg;
    result_t     owed[$];
    int unsigned mismatches;

    function new();
      count = 0;
      next_id = 32'd1;
      limit_reg = '0;
      mismatches = 0;
    endfunction

    function void set_limit(logic [4:0] v);
      limit_reg = v;
    endfunction

    function int unsigned pending();
      return count;
    endfunction

    // Shift out entry pos, closing the gap.
    function void drop(int unsigned pos);
      for (int unsigned i = pos; i + 1 < count; i++) begin
        q_time[i] = q_time[i+1];   q_id[i] = q_id[i+1];
        q_kind[i] = q_kind[i+1];   q_target[i] = q_target[i+1];
        q_size[i] = q_size[i+1];   q_value[i] = q_value[i+1];
      end
      count--;
    endfunction

    function result_t blank(status_e st, logic [31:0] id);
      result_t r;
      r = '0;
      r.status = st;
      r.id = id;
      r.last = 1'b1;
      return r;
    endfunction

    function result_t fired(int unsigned slot, logic [47:0] t);
      result_t r;
      r = blank(ST_FIRED, q_id[slot]);
      r.kind = q_kind[slot];  r.target = q_target[slot];
      r.size = q_size[slot];  r.value = q_value[slot];
      r.ftime = t;
      return r;
    endfunction

    function void note_command(cmd_e cmd, logic [47:0] t, logic [31:0] id,
                               logic [2:0] k, logic [15:0] tg, logic [15:0] sz,
                               logic [31:0] v);
      int unsigned lim, pos, n;
      int slot;
      result_t r;
      case (cmd)
        CMD_INSERT: begin
          lim = (limit_reg == 0 || limit_reg > DEPTH) ? DEPTH : limit_reg;
          if (count >= lim) begin
            owed.push_back(blank(ST_FULL, '0));
          end else begin
            // equal times: newest goes in front
            pos = 0;
            while (pos < count && q_time[pos] < t) pos++;
            for (int unsigned i = count; i > pos; i--) begin
              q_time[i] = q_time[i-1];   q_id[i] = q_id[i-1];
              q_kind[i] = q_kind[i-1];   q_target[i] = q_target[i-1];
              q_size[i] = q_size[i-1];   q_value[i] = q_value[i-1];
            end
            q_time[pos] = t;  q_id[pos] = next_id;  q_kind[pos] = k;
            q_target[pos] = tg;  q_size[pos] = sz;  q_value[pos] = v;
            count++;
            owed.push_back(blank(ST_QUEUED, next_id));
            next_id = next_id + 32'd1;
          end
        end
        CMD_REMOVE, CMD_EXECUTE: begin
          slot = -1;
          for (int i = count - 1; i >= 0; i--) if (q_id[i] == id) slot = i;
          if (slot < 0) begin
            owed.push_back(blank(ST_NOT_FOUND, '0));
          end else begin
            if (cmd == CMD_REMOVE) owed.push_back(blank(ST_QUEUED, id));
            else owed.push_back(fired(slot, '0));
            drop(slot);
          end
        end
        default: begin
          n = 0;
          while (n < MAX_RESULTS && count > 0 && q_time[0] <= t) begin
            r = fired(0, t);
            r.last = 1'b0;
            owed.push_back(r);
            drop(0);
            n++;
          end
          if (n == 0) owed.push_back(blank(ST_NONE_DUE, '0));
          else owed[$].last = 1'b1;
        end
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
        return;
      end
      want = owed.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("result mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [4:0]  cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  command_i = '0;
  logic [47:0] time_value_i = '0;
  logic [31:0] event_id_i = '0;
  logic [2:0]  action_kind_i = '0;
  logic [15:0] target_handle_i = '0;
  logic [15:0] bitmap_size_i = '0;
  logic signed [31:0] action_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [31:0] result_id_o;
  logic [2:0]  fired_kind_o;
  logic [15:0] fired_target_o;
  logic [15:0] fired_size_o;
  logic signed [31:0] fired_value_o;
  logic [47:0] fire_time_o;
  logic        last_result_o;

  event_scoreboard sb = new();
  bit   calm;          // no idling on either side while set
  int unsigned idle_cycles;
  logic [47:0] now_t;  // running service clock for the random part

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  timed_event_queue DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .command_i, .time_value_i, .event_id_i, .action_kind_i, .target_handle_i,
    .bitmap_size_i, .action_value_i, .out_valid_o, .out_stall_i, .status_o,
    .result_id_o, .fired_kind_o, .fired_target_o, .fired_size_o, .fired_value_o,
    .fire_time_o, .last_result_o
  );

  // Sample result beats at the rising edge; count cycles with no result beat and no accepted command.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        sb.check_result({status_o, result_id_o, fired_kind_o, fired_target_o,
                         fired_size_o, fired_value_o, fire_time_o, last_result_o});
      end
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WDOG_MAX) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Receiver: stall at random, about 27 in 100, except in calm stretches.
  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 27);
  end

  // Hand one command to the block and note it once accepted. Start a
  // falling edge later than the last drop of valid; the block stalls there.
  task automatic send_cmd(cmd_e cmd, logic [47:0] t, logic [31:0] id,
                          logic [2:0] k, logic [15:0] tg, logic [15:0] sz,
                          logic [31:0] v);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 27) @(negedge clk_i);
    command_i <= cmd;  time_value_i <= t;  event_id_i <= id;
    action_kind_i <= k;  target_handle_i <= tg;  bitmap_size_i <= sz;
    action_value_i <= v;  in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_command(cmd, t, id, k, tg, sz, v);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic insert_ev(logic [47:0] t);
    send_cmd(CMD_INSERT, t, $urandom, 3'($urandom_range(7)), 16'($urandom),
             16'($urandom), $urandom);
  endtask

  // Hold until every owed result has come, plus a margin for the sequencer.
  task automatic drain();
    while (sb.owed.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic write_limit(logic [4:0] v);
    drain();
    cfg_wdata_i <= v;
    cfg_we_i <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_limit(v);
  endtask

  // Pick an id: mostly one likely pending, sometimes a random one.
  function automatic logic [31:0] pick_id();
    if (sb.pending() != 0 && $urandom_range(3) != 0)
      return sb.q_id[$urandom_range(sb.pending() - 1)];
    return $urandom_range(3) == 0 ? $urandom : sb.next_id - $urandom_range(40);
  endfunction

  initial begin
    int unsigned roll;
    calm = 1'b0;
    idle_cycles = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: field extremes, every command, each special case.
    send_cmd(CMD_SERVICE, '1, '0, '0, '0, '0, '0);             // nothing due
    send_cmd(CMD_INSERT, 48'd100, '0, 3'd0, '0, '0, 32'h8000_0000);
    send_cmd(CMD_INSERT, 48'd100, '1, 3'd7, '1, '1, 32'h7FFF_FFFF); // equal time
    send_cmd(CMD_INSERT, '1, '1, 3'd4, 16'h1234, 16'd9, '1);
    send_cmd(CMD_INSERT, '0, '0, 3'd5, 16'hABCD, 16'd0, 32'd5);
    send_cmd(CMD_EXECUTE, '1, 32'd2, '0, '0, '0, '0);
    send_cmd(CMD_REMOVE, '0, 32'd1, '0, '0, '0, '0);
    send_cmd(CMD_REMOVE, '0, 32'd1, '0, '0, '0, '0);             // unknown id
    send_cmd(CMD_EXECUTE, '0, '1, '0, '0, '0, '0);               // unknown id
    send_cmd(CMD_SERVICE, 48'd99, '0, '0, '0, '0, '0);
    send_cmd(CMD_SERVICE, '1, '0, '0, '0, '0, '0);
    // Fill to the limit, overflow, then service the full queue twice.
    write_limit(5'd2);
    repeat (3) insert_ev(48'd7);
    write_limit(5'd31);
    repeat (15) insert_ev(48'($urandom_range(20)));
    send_cmd(CMD_SERVICE, 48'd30, '0, '0, '0, '0, '0);
    send_cmd(CMD_SERVICE, 48'd30, '0, '0, '0, '0, '0);
    write_limit(5'd0);

    // Random part: mostly a live queue with inserts near the service clock.
    now_t = 48'd1000;
    for (int n = 0; n < 190; n++) begin
      calm = (n >= 80 && n < 120);
      if (n == 60) write_limit(5'd1);
      if (n == 100) write_limit(5'd16);
      if (n == 140) write_limit(5'($urandom_range(3, 15)));
      if (n == 180) write_limit(5'd0);
      if (n == 150) drain();                          // sender pauses for all results
      roll = $urandom_range(99);
      if (roll < 45) begin
        send_cmd(CMD_INSERT,
                 48'($urandom_range(9) == 0 ? {$urandom, $urandom}
                                             : now_t + $urandom_range(60)),
                 $urandom, 3'($urandom_range(7)), 16'($urandom), 16'($urandom),
                 $urandom);
      end else if (roll < 60) begin
        send_cmd(CMD_REMOVE, 48'($urandom), pick_id(), 3'($urandom), 16'($urandom),
                 16'($urandom), $urandom);
      end else if (roll < 75) begin
        send_cmd(CMD_EXECUTE, 48'($urandom), pick_id(), 3'($urandom), 16'($urandom),
                 16'($urandom), $urandom);
      end else begin
        now_t = now_t + $urandom_range(40);
        send_cmd(CMD_SERVICE, now_t, $urandom, 3'($urandom), 16'($urandom),
                 16'($urandom), $urandom);
      end
    end
    send_cmd(CMD_SERVICE, '1, '0, '0, '0, '0, '0);

    calm = 1'b0;
    drain();
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
